// ===== design/generation_tagged_slot_allocator_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Slot allocator assertion macros
// Immediate-implication and next-cycle-implication property wrappers.
// ----------------------------------------------------------------------------
`ifndef GENERATION_TAGGED_SLOT_ALLOCATOR_UNIT_MACROS_SVH
`define GENERATION_TAGGED_SLOT_ALLOCATOR_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GTSA_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("slot allocator assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define GTSA_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("slot allocator assertion failed");

`endif

// ===== design/gtsa_pkg.sv =====
// ----------------------------------------------------------------------------
// Slot allocator package
// Sizes, request codes, controller states and shared structs.
// ----------------------------------------------------------------------------
`default_nettype none

package gtsa_pkg;

    localparam int NUM_SLOTS  = 256;
    localparam int SLOT_W     = $clog2(NUM_SLOTS);
    localparam int COUNT_W    = $clog2(NUM_SLOTS + 1);
    localparam int GEN_W      = 32;
    localparam int IDX_W      = 10;
    localparam int GRANT_W    = 8;
    localparam int LIVE_W     = 9;

    // Two-level free search: groups of 16 flags
    localparam int GRP_SIZE   = 16;
    localparam int GRP_BIT_W  = $clog2(GRP_SIZE);
    localparam int NUM_GROUPS = (NUM_SLOTS + GRP_SIZE - 1) / GRP_SIZE;
    localparam int GRP_IDX_W  = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
    localparam int PAD_SLOTS  = NUM_GROUPS * GRP_SIZE;

    // Stream payload widths
    localparam int S_TDATA_W  = 48;
    localparam int M_TDATA_W  = 56;
    localparam int M_PAD_W    = M_TDATA_W - LIVE_W - GEN_W - GRANT_W;

    localparam logic REQ_ALLOC   = 1'b0;
    localparam logic REQ_RELEASE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PICK,
        ST_ISSUE,
        ST_EVAL
    } state_t;

    typedef struct packed {
        logic              found;
        logic [SLOT_W-1:0] slot;
    } find_result_t;

endpackage

`default_nettype wire

// ===== design/generation_tagged_slot_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// Generation-tagged slot allocator
// Hands out the lowest free slot with its generation tag and checks release
// tokens against the stored generation.
// ----------------------------------------------------------------------------
// A request is one transaction on the s_ side; each request yields exactly one
// result transaction on the m_ side, in order. One request is in work at a
// time: an allocate goes through finding the first group with a free slot,
// picking the slot inside it, reading the generation memory, and evaluating
// and writing back; a release goes through the memory read and then evaluate
// and write back. The result sits in an output register, so a waiting result
// blocks the next request only when it must itself be replaced. Generation
// tags live in a 256 x 32 RAM; a per-slot written bit makes never-written
// slots read as generation 0, so no clearing pass is needed after reset.
// Active flags are flip-flops cleared by reset.
// ----------------------------------------------------------------------------
`default_nettype none

module generation_tagged_slot_allocator_unit (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // request channel
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [gtsa_pkg::S_TDATA_W-1:0]  s_tdata,  // slot_index, token_generation
    input  wire logic [0:0]                      s_tuser,  // req_type
    // result channel
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic      [gtsa_pkg::M_TDATA_W-1:0]  m_tdata,  // granted_slot, granted_generation,
                                                           // live_count
    output logic      [0:0]                      m_tuser   // ok
);

    import gtsa_pkg::*;

    `include "generation_tagged_slot_allocator_unit_macros.svh"

    state_t state_reg, state_next;

    // Request capture
    logic              req_type_reg;
    logic [GEN_W-1:0]  token_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic              found_reg;

    // Slot state
    logic [NUM_SLOTS-1:0] flags_reg;
    logic [NUM_SLOTS-1:0] written_reg;
    logic [COUNT_W-1:0]   count_reg;
    logic [COUNT_W-1:0]   count_next;

    // Output register
    logic                 m_valid_reg;
    logic [M_TDATA_W-1:0] m_data_reg;
    logic                 m_ok_reg;

    // Control
    logic         accept;
    logic         out_free;
    logic         scan_en;
    logic         pick_en;
    logic         ram_re;
    logic         eval_fire;
    find_result_t find_res;

    logic [GEN_W-1:0]   rdata;
    logic [GEN_W-1:0]   cur_gen;
    logic               rel_ok;
    logic               alloc_ok;
    logic               res_ok;
    logic [GRANT_W-1:0] res_slot;
    logic [GEN_W-1:0]   res_gen;
    logic               ram_we;
    logic [IDX_W-1:0]   in_slot;

    assign in_slot  = s_tdata[IDX_W-1:0];
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = (s_tuser[0] == REQ_RELEASE) ? ST_ISSUE : ST_SCAN;
                end
            end
            ST_SCAN:  state_next = ST_PICK;
            ST_PICK:  state_next = ST_ISSUE;
            ST_ISSUE: state_next = ST_EVAL;
            ST_EVAL: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        s_tready  = 1'b0;
        scan_en   = 1'b0;
        pick_en   = 1'b0;
        ram_re    = 1'b0;
        eval_fire = 1'b0;
        case (state_reg)
            ST_IDLE:  s_tready  = 1'b1;
            ST_SCAN:  scan_en   = 1'b1;
            ST_PICK:  pick_en   = 1'b1;
            ST_ISSUE: ram_re    = 1'b1;
            ST_EVAL:  eval_fire = out_free;
            default:  s_tready  = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Capture the request; a release resolves its slot and range at once
    always_ff @(posedge aclk) begin
        if (accept) begin
            req_type_reg <= s_tuser[0];
            token_reg    <= s_tdata[IDX_W +: GEN_W];
            slot_reg     <= SLOT_W'(in_slot);
            found_reg    <= (32'(in_slot) < NUM_SLOTS);
        end else if (pick_en) begin
            slot_reg     <= find_res.slot;
            found_reg    <= find_res.found;
        end
    end

    gtsa_finder u_finder (
        .aclk    (aclk),
        .aresetn (aresetn),
        .scan_en (scan_en),
        .flags   (flags_reg),
        .result  (find_res)
    );

    gtsa_ram #(
        .WIDTH (GEN_W),
        .DEPTH (NUM_SLOTS)
    ) u_gen_ram (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (slot_reg),
        .wdata (cur_gen + GEN_W'(1)),
        .re    (ram_re),
        .raddr (slot_reg),
        .rdata (rdata)
    );

    // Evaluate: a never-written slot holds generation zero
    assign cur_gen  = written_reg[slot_reg] ? rdata : '0;
    assign alloc_ok = found_reg;
    assign rel_ok   = found_reg && flags_reg[slot_reg] && (cur_gen == token_reg);
    assign ram_we   = eval_fire && (req_type_reg == REQ_RELEASE) && rel_ok;

    always_comb begin
        count_next = count_reg;
        res_ok     = 1'b0;
        res_slot   = '0;
        res_gen    = '0;
        if (req_type_reg == REQ_ALLOC) begin
            res_ok = alloc_ok;
            if (alloc_ok) begin
                count_next = count_reg + COUNT_W'(1);
                res_slot   = GRANT_W'(slot_reg);
                res_gen    = cur_gen;
            end
        end else begin
            res_ok = rel_ok;
            if (rel_ok && (count_reg != '0)) begin
                count_next = count_reg - COUNT_W'(1);
            end
        end
    end

    // Write back flags, written bits and live count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flags_reg   <= '0;
            written_reg <= '0;
            count_reg   <= '0;
        end else if (eval_fire) begin
            count_reg <= count_next;
            if (req_type_reg == REQ_ALLOC) begin
                if (alloc_ok) begin
                    flags_reg[slot_reg] <= 1'b1;
                end
            end else if (rel_ok) begin
                flags_reg[slot_reg]   <= 1'b0;
                written_reg[slot_reg] <= 1'b1;
            end
        end
    end

    // Output register: load on evaluate, drop on downstream transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (eval_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (eval_fire) begin
            m_ok_reg   <= res_ok;
            m_data_reg <= {{M_PAD_W{1'b0}}, LIVE_W'(count_next), res_gen, res_slot};
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tuser[0] = m_ok_reg;

    // Live count always equals the number of active flags
    `GTSA_ASSERT_NOW(a_count_matches_flags, aclk, aresetn, 1'b1,
        count_reg == COUNT_W'($countones(flags_reg)))
    // Only one request in work at a time
    `GTSA_ASSERT_NEXT(a_one_in_flight, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    // A successful release leaves its slot inactive
    `GTSA_ASSERT_NEXT(a_release_clears, aclk, aresetn,
        eval_fire && (req_type_reg == REQ_RELEASE) && rel_ok, !flags_reg[slot_reg])

endmodule

`default_nettype wire

// ===== design/gtsa_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module gtsa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        // hold read data until the next read
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== design/gtsa_finder.sv =====
// ----------------------------------------------------------------------------
// Slot allocator free-slot finder
// Lowest inactive slot in two steps: first free group, then bit in group.
// ----------------------------------------------------------------------------
`default_nettype none

module gtsa_finder (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            scan_en,
    input  wire logic [gtsa_pkg::NUM_SLOTS-1:0]  flags,
    output gtsa_pkg::find_result_t               result
);

    import gtsa_pkg::*;

    logic [PAD_SLOTS-1:0] flags_pad;
    logic [GRP_IDX_W-1:0] grp_next;
    logic [GRP_IDX_W-1:0] grp_reg;
    logic                 hit_next;
    logic                 hit_reg;
    logic [GRP_SIZE-1:0]  grp_word;
    logic [GRP_BIT_W-1:0] bit_sel;

    // Padding slots count as occupied
    always_comb begin
        flags_pad = '1;
        flags_pad[NUM_SLOTS-1:0] = flags;
    end

    always_comb begin
        hit_next = 1'b0;
        grp_next = '0;
        for (int g = NUM_GROUPS - 1; g >= 0; g--) begin
            if (!(&flags_pad[g*GRP_SIZE +: GRP_SIZE])) begin
                hit_next = 1'b1;
                grp_next = GRP_IDX_W'(g);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_reg <= 1'b0;
        end else if (scan_en) begin
            hit_reg <= hit_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (scan_en) begin
            grp_reg <= grp_next;
        end
    end

    assign grp_word = flags_pad[grp_reg*GRP_SIZE +: GRP_SIZE];

    always_comb begin
        bit_sel = '0;
        for (int b = GRP_SIZE - 1; b >= 0; b--) begin
            if (!grp_word[b]) begin
                bit_sel = GRP_BIT_W'(b);
            end
        end
    end

    assign result.found = hit_reg;
    assign result.slot  = SLOT_W'({grp_reg, bit_sel});

endmodule

`default_nettype wire
